// ----- hdl/rmj_pkg.sv -----
// shared constants, types and helpers for the radar measurement jacobian
// no dependencies
package rmj_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QuotBits    = DataW + 1;
  localparam int unsigned SqrtSteps   = DataW;
  localparam int unsigned DivLat      = QuotBits + 1;

  localparam logic [DataW-1:0]    LimitRst = 32'd4295;
  localparam logic [QuotBits-1:0] SatPosQ  = 33'h0_7FFF_FFFF;
  localparam logic [QuotBits-1:0] SatNegQ  = 33'h0_8000_0000;
  localparam logic [DataW-1:0]    SatPos   = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]    SatNeg   = 32'h8000_0000;

  typedef struct packed {
    logic [DataW-1:0]   mpx;
    logic [DataW-1:0]   mpy;
    logic               spx;
    logic               spy;
    logic [2*DataW-1:0] mc;
    logic               sc;
    logic [2*DataW-1:0] r2;
    logic               tc;
  } rmj_side_t;

  function automatic logic [DataW-1:0] mag32(logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ----- hdl/rmj_in_if.sv -----
// input channel carrying one track state per transaction
// no dependencies
interface rmj_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// ----- hdl/rmj_out_if.sv -----
// output channel carrying the jacobian entries per transaction
// no dependencies
interface rmj_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_dx;
  logic [31:0] range_dy;
  logic [31:0] bearing_dx;
  logic [31:0] bearing_dy;
  logic [31:0] rate_dx;
  logic [31:0] rate_dy;
  logic        too_close;
  modport source (output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
                  too_close, input ready);
  modport sink (input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
                too_close, output ready);
endinterface

// ----- hdl/rmj_sqrt_cell.sv -----
// one step of the square root chain, one result bit per cell
// depends on rmj_pkg
module rmj_sqrt_cell import rmj_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*DataW-1:0] n_i,
  input  logic [2*DataW-1:0] res_i,
  input  rmj_side_t          side_i,
  output logic [2*DataW-1:0] n_o,
  output logic [2*DataW-1:0] res_o,
  output rmj_side_t          side_o
);
  localparam logic [2*DataW-1:0] One = 64'd1 << (2*DataW - 2 - 2*IDX);

  logic [2*DataW-1:0] trial;
  logic [2*DataW-1:0] n_d, n_q, res_d, res_q;
  rmj_side_t          side_q;

  always_comb begin
    trial = res_i + One;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + One;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign n_o    = n_q;
  assign res_o  = res_q;
  assign side_o = side_q;
endmodule

// ----- hdl/rmj_div_cell.sv -----
// one restoring division step, one quotient bit per cell
// depends on rmj_pkg
module rmj_div_cell import rmj_pkg::*; #(
  parameter int unsigned RW    = 64,
  parameter int unsigned DW    = 32,
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [RW-1:0]       rem_i,
  input  logic [DW-1:0]       den_i,
  input  logic [QuotBits-1:0] q_i,
  input  logic                neg_i,
  input  logic                ovf_i,
  output logic [RW-1:0]       rem_o,
  output logic [DW-1:0]       den_o,
  output logic [QuotBits-1:0] q_o,
  output logic                neg_o,
  output logic                ovf_o
);
  logic [RW-1:0]       dsh;
  logic                ge;
  logic [RW-1:0]       rem_q;
  logic [DW-1:0]       den_q;
  logic [QuotBits-1:0] q_q;
  logic                neg_q, ovf_q;

  assign dsh = RW'(den_i) << SHIFT;
  assign ge  = rem_i >= dsh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? rem_i - dsh : rem_i;
      q_q   <= ge ? (q_i | (QuotBits'(1) << SHIFT)) : q_i;
      den_q <= den_i;
      neg_q <= neg_i;
      ovf_q <= ovf_i;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;
  assign ovf_o = ovf_q;
endmodule

// ----- hdl/rmj_div.sv -----
// rounded signed divider built as a chain of division cells, saturating result
// depends on rmj_pkg and rmj_div_cell
module rmj_div import rmj_pkg::*; #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic             neg_i,
  output logic [DataW-1:0] res_o
);
  localparam int unsigned RW = (NW + 1 > DW + QuotBits) ? NW + 1 : DW + QuotBits;

  logic [RW-1:0]       sum;
  logic [RW-1:0]       rem [QuotBits+1];
  logic [DW-1:0]       den [QuotBits+1];
  logic [QuotBits-1:0] q   [QuotBits+1];
  logic                neg [QuotBits+1];
  logic                ovf [QuotBits+1];
  logic [RW-1:0]       rem_q;
  logic [DW-1:0]       den_q;
  logic                neg_q, ovf_q;
  logic [QuotBits-1:0] qf;

  assign sum = RW'(num_i) + RW'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= sum;
      den_q <= den_i;
      neg_q <= neg_i;
      ovf_q <= sum >= (RW'(den_i) << QuotBits);
    end
  end

  assign rem[0] = rem_q;
  assign den[0] = den_q;
  assign q[0]   = '0;
  assign neg[0] = neg_q;
  assign ovf[0] = ovf_q;

  for (genvar k = 0; k < QuotBits; k++) begin : g_cell
    rmj_div_cell #(.RW(RW), .DW(DW), .SHIFT(QuotBits - 1 - k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem[k]),
      .den_i (den[k]),
      .q_i   (q[k]),
      .neg_i (neg[k]),
      .ovf_i (ovf[k]),
      .rem_o (rem[k+1]),
      .den_o (den[k+1]),
      .q_o   (q[k+1]),
      .neg_o (neg[k+1]),
      .ovf_o (ovf[k+1])
    );
  end

  assign qf = q[QuotBits];

  always_comb begin
    if (neg[QuotBits]) begin
      res_o = (ovf[QuotBits] || qf > SatNegQ) ? SatNeg : (~qf[DataW-1:0] + 32'd1);
    end else begin
      res_o = (ovf[QuotBits] || qf > SatPosQ) ? SatPos : qf[DataW-1:0];
    end
  end
endmodule

// ----- hdl/radar_measurement_jacobian.sv -----
// Radar measurement jacobian: takes one track state (px, py, vx, vy, signed fixed point
// with FRAC_BITS fraction bits) per cycle and returns px/r, py/r, -py/r^2, px/r^2,
// py*det and -px*det, rounded to nearest and saturated. A transaction is accepted every
// cycle while the output side keeps up; its result passes through the 32-cell square root
// chain and the 33-cell division chains. A squared range below
// the near_zero_limit register (or zero) gives all-zero entries with too_close set.
module radar_measurement_jacobian import rmj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rmj_in_if.sink           in_i,
  rmj_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i
);
  localparam int unsigned Nw0 = DataW + FRAC_BITS;
  localparam int unsigned Nw2 = 2*DataW + 2*FRAC_BITS;
  localparam int unsigned Nw4 = 3*DataW + FRAC_BITS;
  localparam int unsigned Lat = 3 + SqrtSteps + 2 + DivLat;

  logic en;
  logic [DataW-1:0] limit_q;
  logic [Lat-1:0]   vld_q;
  logic             out_vld_q;

  // stage 1: magnitudes
  logic [DataW-1:0] mpx1_q, mpy1_q, mvx1_q, mvy1_q;
  logic             spx1_q, spy1_q, svx1_q, svy1_q;
  // stage 2: products
  logic [2*DataW-1:0] px2_q, py2_q, m1_q, m2_q;
  logic [DataW-1:0]   mpx2_q, mpy2_q;
  logic               spx2_q, spy2_q, s1_q, s2_q;
  // stage 3: squared range and cross term
  rmj_side_t          s3_q;
  rmj_side_t          s3_in;
  rmj_side_t          side [SqrtSteps+1];
  logic [2*DataW-1:0] sn   [SqrtSteps+1];
  logic [2*DataW-1:0] sr   [SqrtSteps+1];
  // stage 5: partial products
  rmj_side_t          s5_q;
  logic [DataW-1:0]   r5_q;
  logic [2*DataW-1:0] pd_lo_q, pd_hi_q, ym_lo_q, ym_hi_q, xm_lo_q, xm_hi_q;
  // stage 6: full products
  rmj_side_t          s6_q;
  logic [DataW-1:0]   r6_q;
  logic [3*DataW-1:0] d3_q, ym_q, xm_q;
  logic [DivLat-1:0]  tc_q;
  logic [DataW-1:0]   e0, e1, e2, e3, e4, e5;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitRst;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q     <= {vld_q[Lat-2:0], in_i.valid};
        out_vld_q <= vld_q[Lat-1];
      end
    end
  end

  always_comb begin
    s3_in    = s3_q;
    s3_in.tc = (s3_q.r2 == '0) || (s3_q.r2 < {32'd0, limit_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mpx1_q <= mag32(in_i.pos_x);
      mpy1_q <= mag32(in_i.pos_y);
      mvx1_q <= mag32(in_i.vel_x);
      mvy1_q <= mag32(in_i.vel_y);
      spx1_q <= in_i.pos_x[DataW-1];
      spy1_q <= in_i.pos_y[DataW-1];
      svx1_q <= in_i.vel_x[DataW-1];
      svy1_q <= in_i.vel_y[DataW-1];

      px2_q  <= 64'(mpx1_q) * 64'(mpx1_q);
      py2_q  <= 64'(mpy1_q) * 64'(mpy1_q);
      m1_q   <= 64'(mvx1_q) * 64'(mpy1_q);
      m2_q   <= 64'(mvy1_q) * 64'(mpx1_q);
      mpx2_q <= mpx1_q;
      mpy2_q <= mpy1_q;
      spx2_q <= spx1_q;
      spy2_q <= spy1_q;
      s1_q   <= svx1_q != spy1_q;
      s2_q   <= svy1_q == spx1_q;

      s3_q.mpx <= mpx2_q;
      s3_q.mpy <= mpy2_q;
      s3_q.spx <= spx2_q;
      s3_q.spy <= spy2_q;
      s3_q.r2  <= px2_q + py2_q;
      s3_q.tc  <= 1'b0;
      if (s1_q == s2_q) begin
        s3_q.mc <= m1_q + m2_q;
        s3_q.sc <= s1_q;
      end else if (m1_q >= m2_q) begin
        s3_q.mc <= m1_q - m2_q;
        s3_q.sc <= s1_q;
      end else begin
        s3_q.mc <= m2_q - m1_q;
        s3_q.sc <= s2_q;
      end
    end
  end

  assign sn[0]   = s3_q.r2;
  assign sr[0]   = '0;
  assign side[0] = s3_in;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    rmj_sqrt_cell #(.IDX(k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .n_i    (sn[k]),
      .res_i  (sr[k]),
      .side_i (side[k]),
      .n_o    (sn[k+1]),
      .res_o  (sr[k+1]),
      .side_o (side[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q    <= side[SqrtSteps];
      r5_q    <= sr[SqrtSteps][DataW-1:0];
      pd_lo_q <= 64'(side[SqrtSteps].r2[DataW-1:0]) * 64'(sr[SqrtSteps][DataW-1:0]);
      pd_hi_q <= 64'(side[SqrtSteps].r2[2*DataW-1:DataW]) * 64'(sr[SqrtSteps][DataW-1:0]);
      ym_lo_q <= 64'(side[SqrtSteps].mpy) * 64'(side[SqrtSteps].mc[DataW-1:0]);
      ym_hi_q <= 64'(side[SqrtSteps].mpy) * 64'(side[SqrtSteps].mc[2*DataW-1:DataW]);
      xm_lo_q <= 64'(side[SqrtSteps].mpx) * 64'(side[SqrtSteps].mc[DataW-1:0]);
      xm_hi_q <= 64'(side[SqrtSteps].mpx) * 64'(side[SqrtSteps].mc[2*DataW-1:DataW]);

      s6_q <= s5_q;
      r6_q <= r5_q;
      d3_q <= (96'(pd_hi_q) << DataW) + 96'(pd_lo_q);
      ym_q <= (96'(ym_hi_q) << DataW) + 96'(ym_lo_q);
      xm_q <= (96'(xm_hi_q) << DataW) + 96'(xm_lo_q);

      tc_q <= {tc_q[DivLat-2:0], s6_q.tc};
    end
  end

  rmj_div #(.NW(Nw0), .DW(DataW)) u_div0 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw0'(s6_q.mpx) << FRAC_BITS),
    .den_i (r6_q), .neg_i (s6_q.spx), .res_o (e0)
  );
  rmj_div #(.NW(Nw0), .DW(DataW)) u_div1 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw0'(s6_q.mpy) << FRAC_BITS),
    .den_i (r6_q), .neg_i (s6_q.spy), .res_o (e1)
  );
  rmj_div #(.NW(Nw2), .DW(2*DataW)) u_div2 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw2'(s6_q.mpy) << (2*FRAC_BITS)),
    .den_i (s6_q.r2), .neg_i (!s6_q.spy), .res_o (e2)
  );
  rmj_div #(.NW(Nw2), .DW(2*DataW)) u_div3 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw2'(s6_q.mpx) << (2*FRAC_BITS)),
    .den_i (s6_q.r2), .neg_i (s6_q.spx), .res_o (e3)
  );
  rmj_div #(.NW(Nw4), .DW(3*DataW)) u_div4 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw4'(ym_q) << FRAC_BITS),
    .den_i (d3_q), .neg_i (s6_q.spy != s6_q.sc), .res_o (e4)
  );
  rmj_div #(.NW(Nw4), .DW(3*DataW)) u_div5 (
    .clk_i (clk_i), .en_i (en), .num_i (Nw4'(xm_q) << FRAC_BITS),
    .den_i (d3_q), .neg_i (s6_q.spx == s6_q.sc), .res_o (e5)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.range_dx   <= tc_q[DivLat-1] ? '0 : e0;
      out_o.range_dy   <= tc_q[DivLat-1] ? '0 : e1;
      out_o.bearing_dx <= tc_q[DivLat-1] ? '0 : e2;
      out_o.bearing_dy <= tc_q[DivLat-1] ? '0 : e3;
      out_o.rate_dx    <= tc_q[DivLat-1] ? '0 : e4;
      out_o.rate_dy    <= tc_q[DivLat-1] ? '0 : e5;
      out_o.too_close  <= tc_q[DivLat-1];
    end
  end

  assign out_o.valid = out_vld_q;
endmodule

// ----- hdl/rmj_checker.sv -----
// port-level assertions for the radar measurement jacobian, bound to the top level
// depends on radar_measurement_jacobian
module rmj_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] range_dx,
  input logic [31:0] range_dy,
  input logic [31:0] bearing_dx,
  input logic [31:0] bearing_dy,
  input logic [31:0] rate_dx,
  input logic [31:0] rate_dy,
  input logic        too_close
);
  localparam logic signed [31:0] Unit = 32'sd1 <<< FRAC_BITS;

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && too_close |-> range_dx == '0 && range_dy == '0 && bearing_dx == '0 &&
      bearing_dy == '0 && rate_dx == '0 && rate_dy == '0)
    else $error("too_close transaction with nonzero entries");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(range_dx) && $stable(too_close))
    else $error("stalled output transaction changed");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !too_close |-> $signed(range_dx) <= Unit && $signed(range_dx) >= -Unit &&
      $signed(range_dy) <= Unit && $signed(range_dy) >= -Unit)
    else $error("range derivative beyond one");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_valid) && !$isunknown(out_valid))
    else $error("unknown valid");
endmodule

bind radar_measurement_jacobian rmj_checker #(.FRAC_BITS(FRAC_BITS)) u_rmj_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .range_dx   (out_o.range_dx),
  .range_dy   (out_o.range_dy),
  .bearing_dx (out_o.bearing_dx),
  .bearing_dy (out_o.bearing_dy),
  .rate_dx    (out_o.rate_dx),
  .rate_dy    (out_o.rate_dy),
  .too_close  (out_o.too_close)
);
